### design/sks_pkg.sv
// shared types and constants of the sorted key set
package sks_pkg;

  localparam int CMD_W   = 3;
  localparam int KEY_W   = 32;
  localparam int RANK_W  = 6;
  localparam int COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CONTAINS = 3'd2;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SHIFT_DN,
    ST_RANK_GET,
    ST_RESP
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_INC,
    IDX_DEC,
    IDX_TOP,
    IDX_RANK
  } idx_op_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_UP,
    WR_DOWN,
    WR_KEY
  } wr_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef struct packed {
    logic    load;
    idx_op_t idx_op;
    logic    save_pos;
    wr_op_t  wr_op;
    cnt_op_t cnt_op;
    logic    hit_set;
    logic    full_set;
    logic    rd_set;
    logic    out_load;
  } ctrl_t;

  typedef struct packed {
    logic             at_end;
    logic             below;
    logic             equal;
    logic             full;
    logic             idx_at_pos;
    logic             idx_at_last;
    logic             rank_ok;
    logic             out_hold;
    logic [CMD_W-1:0] cmd;
  } status_t;

endpackage

### design/sks_ctrl.sv
// command sequencer of the sorted key set
module sks_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  sks_pkg::status_t status,
  output sks_pkg::ctrl_t   ctrl
);
  import sks_pkg::*;

  state_t state;
  state_t state_next;
  logic   found;

  assign found = !status.at_end && status.equal;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_START;
      end
      ST_START: begin
        case (status.cmd)
          CMD_INSERT, CMD_REMOVE, CMD_CONTAINS: state_next = ST_SCAN;
          CMD_READ: state_next = status.rank_ok ? ST_RANK_GET : ST_RESP;
          default: state_next = ST_RESP;
        endcase
      end
      ST_SCAN: begin
        if (status.at_end || !status.below) begin
          case (status.cmd)
            CMD_INSERT: begin
              if (found || status.full) begin
                state_next = ST_RESP;
              end else if (status.at_end) begin
                state_next = ST_PUT;
              end else begin
                state_next = ST_SHIFT_UP;
              end
            end
            CMD_REMOVE: begin
              if (found && !status.idx_at_last) begin
                state_next = ST_SHIFT_DN;
              end else begin
                state_next = ST_RESP;
              end
            end
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_SHIFT_UP: begin
        if (status.idx_at_pos) state_next = ST_PUT;
      end
      ST_PUT:      state_next = ST_RESP;
      ST_SHIFT_DN: begin
        if (status.idx_at_last) state_next = ST_RESP;
      end
      ST_RANK_GET: state_next = ST_RESP;
      ST_RESP: begin
        if (!status.out_hold) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl.load     = 1'b0;
    ctrl.idx_op   = IDX_HOLD;
    ctrl.save_pos = 1'b0;
    ctrl.wr_op    = WR_NONE;
    ctrl.cnt_op   = CNT_HOLD;
    ctrl.hit_set  = 1'b0;
    ctrl.full_set = 1'b0;
    ctrl.rd_set   = 1'b0;
    ctrl.out_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.load   = 1'b1;
          ctrl.idx_op = IDX_ZERO;
        end
      end
      ST_START: begin
        case (status.cmd)
          CMD_READ: begin
            if (status.rank_ok) ctrl.idx_op = IDX_RANK;
          end
          CMD_CLEAR: begin
            ctrl.cnt_op  = CNT_CLR;
            ctrl.hit_set = 1'b1;
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (!status.at_end && status.below) begin
          ctrl.idx_op = IDX_INC;
        end else begin
          ctrl.save_pos = 1'b1;
          case (status.cmd)
            CMD_INSERT: begin
              if (!found && status.full) begin
                ctrl.full_set = 1'b1;
              end else if (!found && !status.at_end) begin
                ctrl.idx_op = IDX_TOP;
              end
            end
            CMD_REMOVE: begin
              if (found) begin
                ctrl.hit_set = 1'b1;
                if (status.idx_at_last) begin
                  ctrl.cnt_op = CNT_DEC;
                end else begin
                  ctrl.idx_op = IDX_INC;
                end
              end
            end
            CMD_CONTAINS: ctrl.hit_set = found;
            default: ;
          endcase
        end
      end
      ST_SHIFT_UP: begin
        ctrl.wr_op = WR_UP;
        if (!status.idx_at_pos) ctrl.idx_op = IDX_DEC;
      end
      ST_PUT: begin
        ctrl.wr_op   = WR_KEY;
        ctrl.cnt_op  = CNT_INC;
        ctrl.hit_set = 1'b1;
      end
      ST_SHIFT_DN: begin
        ctrl.wr_op = WR_DOWN;
        if (status.idx_at_last) begin
          ctrl.cnt_op = CNT_DEC;
        end else begin
          ctrl.idx_op = IDX_INC;
        end
      end
      ST_RANK_GET: begin
        ctrl.rd_set  = 1'b1;
        ctrl.hit_set = 1'b1;
      end
      ST_RESP: begin
        ctrl.out_load = !status.out_hold;
      end
      default: ;
    endcase
  end

endmodule

### design/sks_dp.sv
// key memory, scan index, count and result registers of the sorted key set
module sks_dp #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sks_pkg::ctrl_t                      ctrl,
  output sks_pkg::status_t                    status,
  input  logic        [sks_pkg::CMD_W-1:0]    cmd,
  input  logic signed [sks_pkg::KEY_W-1:0]    key,
  input  logic        [sks_pkg::RANK_W-1:0]   rank,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic                                full_res,
  output logic signed [sks_pkg::KEY_W-1:0]    read_key,
  output logic        [sks_pkg::COUNT_W-1:0]  count
);
  import sks_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int MW = (CW > RANK_W) ? CW : RANK_W;

  logic signed [KEY_BITS-1:0] mem [CAPACITY];
  logic signed [KEY_BITS-1:0] rdata;
  logic signed [KEY_BITS-1:0] key_reg;
  logic signed [KEY_BITS-1:0] wdata;
  logic        [CMD_W-1:0]    cmd_reg;
  logic        [RANK_W-1:0]   rank_reg;
  logic        [CW-1:0]       idx;
  logic        [CW-1:0]       idx_next;
  logic        [CW-1:0]       idx_up;
  logic        [CW-1:0]       idx_dn;
  logic        [CW-1:0]       pos;
  logic        [CW-1:0]       key_count;
  logic        [AW-1:0]       raddr;
  logic        [AW-1:0]       waddr;
  logic                       we;
  logic                       hit_flag;
  logic                       full_flag;
  logic        [KEY_W-1:0]    rd_val;

  assign idx_up = idx + 1'b1;
  assign idx_dn = idx - 1'b1;

  always_comb begin
    case (ctrl.idx_op)
      IDX_HOLD: idx_next = idx;
      IDX_ZERO: idx_next = '0;
      IDX_INC:  idx_next = idx_up;
      IDX_DEC:  idx_next = idx_dn;
      IDX_TOP:  idx_next = key_count - 1'b1;
      IDX_RANK: idx_next = CW'(rank_reg);
      default:  idx_next = idx;
    endcase
  end

  // read port is addressed with the next index, so rdata matches idx
  assign raddr = idx_next[AW-1:0];

  always_comb begin
    we    = 1'b1;
    waddr = idx_up[AW-1:0];
    wdata = rdata;
    case (ctrl.wr_op)
      WR_NONE: we = 1'b0;
      WR_UP:   waddr = idx_up[AW-1:0];
      WR_DOWN: waddr = idx_dn[AW-1:0];
      WR_KEY: begin
        waddr = pos[AW-1:0];
        wdata = key_reg;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (ctrl.save_pos) pos <= idx;
    if (ctrl.load) begin
      cmd_reg  <= cmd;
      key_reg  <= KEY_BITS'(key);
      rank_reg <= rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else begin
      case (ctrl.cnt_op)
        CNT_INC: key_count <= key_count + 1'b1;
        CNT_DEC: key_count <= key_count - 1'b1;
        CNT_CLR: key_count <= '0;
        default: key_count <= key_count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      hit_flag  <= 1'b0;
      full_flag <= 1'b0;
      rd_val    <= '0;
    end else begin
      if (ctrl.hit_set)  hit_flag  <= 1'b1;
      if (ctrl.full_set) full_flag <= 1'b1;
      if (ctrl.rd_set)   rd_val    <= KEY_W'($unsigned(rdata));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      hit      <= hit_flag;
      full_res <= full_flag;
      read_key <= $signed(rd_val);
      count    <= COUNT_W'(key_count);
    end
  end

  assign status.at_end      = (idx == key_count);
  assign status.below       = (rdata < key_reg);
  assign status.equal       = (rdata == key_reg);
  assign status.full        = (key_count == CW'(CAPACITY));
  assign status.idx_at_pos  = (idx == pos);
  assign status.idx_at_last = (idx_up == key_count);
  assign status.rank_ok     = (MW'(rank_reg) < MW'(key_count));
  assign status.out_hold    = out_valid && !out_ready;
  assign status.cmd         = cmd_reg;

endmodule

### design/sorted_key_set_top.sv
// top level of the sorted key set
//
//  channel   direction  handshake            payload
//  command   in         in_valid / in_ready  cmd, key, rank
//  result    out        out_valid/out_ready  hit, full_res, read_key, count
//
// one command at a time; the wait for out_valid after the command transfer is shortest for clear,
// unknown codes or a rank past the count, a little longer for a valid read; contains and misses
// depend on where the scan stops, a remove and a new insert on the count before the command,
// set by the linear scan and the one-entry-a-cycle shift
// reset empties the set at once; key memory contents are not cleared
// a waiting result does not stop the next transfer in; a finished command waits only
// while the output register is still occupied
module sorted_key_set_top #(
  parameter int CAPACITY = 64,
  parameter int KEY_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [sks_pkg::CMD_W-1:0]    cmd,
  input  logic signed [sks_pkg::KEY_W-1:0]    key,
  input  logic        [sks_pkg::RANK_W-1:0]   rank,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                hit,
  output logic                                full_res,
  output logic signed [sks_pkg::KEY_W-1:0]    read_key,
  output logic        [sks_pkg::COUNT_W-1:0]  count
);
  import sks_pkg::*;

  // command and status between sequencer and datapath
  ctrl_t   ctrl;
  status_t status;

  // sequencer: scan, shift, write-in and result hand-off
  sks_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .ctrl     (ctrl)
  );

  // datapath: key memory, index, count and the output register
  sks_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .status    (status),
    .cmd       (cmd),
    .key       (key),
    .rank      (rank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .full_res  (full_res),
    .read_key  (read_key),
    .count     (count)
  );

endmodule

### design/sks_checker.sv
// port checks of the sorted key set and their binding
module sks_checker #(
  parameter int CAPACITY = 64
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic                                hit,
  input logic                                full_res,
  input logic signed [sks_pkg::KEY_W-1:0]    read_key,
  input logic        [sks_pkg::COUNT_W-1:0]  count
);
  import sks_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_LOW = COUNT_W'(CAPACITY);

  // a stalled result keeps its fields
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(full_res)
      && $stable(read_key) && $stable(count))
    else $error("result changed while stalled");

  // one command at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken while busy");

  // a rejected insert only happens on a full store
  a_full_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && full_res |-> !hit && count == CAP_LOW)
    else $error("full flag on a store that is not full");

  // a read key only comes with a hit
  a_read_hit: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_key != 0 |-> hit && !full_res)
    else $error("read key without a hit");

endmodule

bind sorted_key_set_top sks_checker #(.CAPACITY(CAPACITY)) u_sks_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .hit       (hit),
  .full_res  (full_res),
  .read_key  (read_key),
  .count     (count)
);

### verif/sorted_key_set_top_test.sv
// testbench for the sorted key set: directed table, fill pass and random phases checked by a predictor
`timescale 1ns / 100ps

module sorted_key_set_top_test;
  import sks_pkg::*;

  localparam int CAPACITY  = 64;
  localparam int POOL_SIZE = 96;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 236;
  localparam int STALL_LEN = 400;
  localparam int IDLE_PCT  = 37;

  // codes the block has no use for; they must leave the set alone
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

  localparam logic [KEY_W-1:0] KEY_MAX = 32'h7fff_ffff;
  localparam logic [KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [KEY_W-1:0] KEY_NEG = 32'hffff_ffff;

  typedef struct packed {
    logic               hit;
    logic               full;
    logic [KEY_W-1:0]   rd;
    logic [COUNT_W-1:0] cnt;
  } set_result_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
    logic              typed;
    set_result_t       res;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  // typed rows carry their result; the rest are left to the predictor
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CMD_READ,     32'd0,       6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd0}},
    '{CMD_CONTAINS, 32'd0,       6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd0}},
    '{CMD_REMOVE,   32'd5,       6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd0}},
    '{CMD_INSERT,   KEY_MAX,     6'd0,  1'b1, '{1'b1, 1'b0, 32'd0,   7'd1}},
    '{CMD_INSERT,   KEY_MIN,     6'd0,  1'b1, '{1'b1, 1'b0, 32'd0,   7'd2}},
    '{CMD_INSERT,   32'd0,       6'd0,  1'b1, '{1'b1, 1'b0, 32'd0,   7'd3}},
    '{CMD_INSERT,   KEY_NEG,     6'd0,  1'b1, '{1'b1, 1'b0, 32'd0,   7'd4}},
    '{CMD_INSERT,   KEY_MAX,     6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd4}},
    '{CMD_READ,     32'd0,       6'd0,  1'b1, '{1'b1, 1'b0, KEY_MIN, 7'd4}},
    '{CMD_READ,     32'd0,       6'd3,  1'b1, '{1'b1, 1'b0, KEY_MAX, 7'd4}},
    '{CMD_READ,     32'd77,      6'd1,  1'b0, '0},
    '{CMD_READ,     32'd0,       6'd4,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd4}},
    '{CMD_READ,     KEY_NEG,     6'd63, 1'b1, '{1'b0, 1'b0, 32'd0,   7'd4}},
    '{CMD_CONTAINS, KEY_NEG,     6'd0,  1'b1, '{1'b1, 1'b0, 32'd0,   7'd4}},
    '{CMD_CONTAINS, 32'd1,       6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd4}},
    '{CMD_REMOVE,   32'd0,       6'd0,  1'b1, '{1'b1, 1'b0, 32'd0,   7'd3}},
    '{CMD_REMOVE,   32'd0,       6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd3}},
    '{CMD_SPARE_A,  32'h5555aaaa, 6'd42, 1'b1, '{1'b0, 1'b0, 32'd0,  7'd3}},
    '{CMD_SPARE_B,  KEY_MIN,     6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd3}},
    '{CMD_SPARE_C,  KEY_NEG,     6'd63, 1'b1, '{1'b0, 1'b0, 32'd0,   7'd3}},
    '{CMD_READ,     32'haaaa5555, 6'd2, 1'b0, '0},
    '{CMD_CLEAR,    32'd123,     6'd21, 1'b1, '{1'b1, 1'b0, 32'd0,   7'd0}},
    '{CMD_CONTAINS, KEY_MAX,     6'd0,  1'b1, '{1'b0, 1'b0, 32'd0,   7'd0}}
  };

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = '0;
  logic signed [KEY_W-1:0] key = '0;
  logic [RANK_W-1:0]   rank = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                hit;
  logic                full_res;
  logic signed [KEY_W-1:0] read_key;
  logic [COUNT_W-1:0]  count;

  sorted_key_set_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .key       (key),
    .rank      (rank),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .hit       (hit),
    .full_res  (full_res),
    .read_key  (read_key),
    .count     (count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: the set as the block should hold it
  logic signed [KEY_W-1:0] model_keys [CAPACITY];
  int                      model_size = 0;

  set_result_t pending_results [$];

  int mismatches = 0;
  int n_sent     = 0;
  int n_refused  = 0;
  int n_clears   = 0;
  int peak_size  = 0;

  // both sides stop idling while this is set
  logic steady = 1'b0;

  // asks the result side for one long hold-off
  logic stall_go = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // apply one command to the predicted set and return its result
  function automatic set_result_t set_apply(input logic [CMD_W-1:0] c,
                                            input logic signed [KEY_W-1:0] k,
                                            input logic [RANK_W-1:0] r);
    set_result_t res;
    int          pos;
    bit          found;
    res = '0;
    pos = 0;
    // linear search for the first slot whose key is not below k
    while (pos < model_size && model_keys[pos] < k) pos++;
    found = (pos < model_size) && (model_keys[pos] == k);
    case (c)
      CMD_INSERT: begin
        // a duplicate is refused quietly, even when the set is full
        if (!found) begin
          if (model_size >= CAPACITY) begin
            res.full = 1'b1;
            n_refused++;
          end else begin
            for (int i = model_size; i > pos; i--) model_keys[i] = model_keys[i-1];
            model_keys[pos] = k;
            model_size++;
            res.hit = 1'b1;
          end
        end
      end
      CMD_REMOVE: begin
        if (found) begin
          for (int i = pos; i < model_size - 1; i++) model_keys[i] = model_keys[i+1];
          model_size--;
          res.hit = 1'b1;
        end
      end
      CMD_CONTAINS: res.hit = found;
      CMD_READ: begin
        // a rank at or past the count reads as a miss with zero key
        if (int'(r) < model_size) begin
          res.hit = 1'b1;
          res.rd  = model_keys[r];
        end
      end
      CMD_CLEAR: begin
        model_size = 0;
        res.hit    = 1'b1;
        n_clears++;
      end
      default: ;
    endcase
    res.cnt = COUNT_W'(model_size);
    if (model_size > peak_size) peak_size = model_size;
    return res;
  endfunction

  // offer one command, hold it until the transfer, then log what must come back
  task automatic offer_cmd(input logic [CMD_W-1:0] c, input logic signed [KEY_W-1:0] k,
                           input logic [RANK_W-1:0] r, input logic typed,
                           input set_result_t typed_res);
    set_result_t pred;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    key      <= k;
    rank     <= r;
    do @(posedge clk); while (!in_ready);
    // the predictor runs for every row so its set stays in step
    pred = set_apply(c, k, r);
    pending_results.push_back(typed ? typed_res : pred);
    n_sent++;
  endtask

  // hold the command side until every result is back
  task automatic wait_drained();
    if (pending_results.size() != 0) begin
      in_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
    end
  endtask

  // result side: check each transfer, then pick ready for the next cycle
  int   hold_cnt    = 0;
  logic stall_taken = 1'b0;

  always @(posedge clk) begin
    set_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending");
      end else begin
        want = pending_results.pop_front();
        if (hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", hit, want.hit));
        if (full_res !== want.full)
          report_mismatch($sformatf("full_res %b, want %b", full_res, want.full));
        if (read_key !== want.rd)
          report_mismatch($sformatf("read_key %0d, want %0d", read_key, $signed(want.rd)));
        if (count !== want.cnt)
          report_mismatch($sformatf("count %0d, want %0d", count, want.cnt));
      end
    end
    // long hold-off so the block fills up and stops taking commands
    if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (stall_go && !stall_taken) begin
      stall_taken <= 1'b1;
      hold_cnt    <= STALL_LEN;
      out_ready   <= 1'b0;
    end else begin
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // keys drawn mostly from a small pool so duplicates, removes and a full set happen often
  logic signed [KEY_W-1:0] key_pool [POOL_SIZE];

  initial begin
    int                      r;
    int                      ins_share;
    int                      rem_share;
    logic [CMD_W-1:0]        c;
    logic signed [KEY_W-1:0] k;
    logic [RANK_W-1:0]       rk;

    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = KEY_NEG;
    key_pool[4] = KEY_MIN + 1;
    key_pool[5] = KEY_MAX - 1;
    for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      offer_cmd(DIR_TABLE[i].cmd, DIR_TABLE[i].key, DIR_TABLE[i].rank,
                DIR_TABLE[i].typed, DIR_TABLE[i].res);

    // fill pass: a scrambled ascending run up to capacity, then the full cases
    for (int i = 0; i < CAPACITY; i++)
      offer_cmd(CMD_INSERT, ((i * 37) % CAPACITY) * 1000 - 32000, '0, 1'b0, '0);
    offer_cmd(CMD_INSERT, 40000, '0, 1'b0, '0);            // new key, set full
    offer_cmd(CMD_INSERT, 0, '0, 1'b0, '0);                // duplicate while full
    offer_cmd(CMD_READ, '0, 6'd63, 1'b0, '0);
    offer_cmd(CMD_REMOVE, KEY_MIN, '0, 1'b0, '0);          // miss
    offer_cmd(CMD_REMOVE, 31000, '0, 1'b0, '0);            // top entry
    offer_cmd(CMD_INSERT, KEY_MIN, '0, 1'b0, '0);          // shifts every entry
    offer_cmd(CMD_READ, '0, 6'd0, 1'b0, '0);
    wait_drained();

    // random phases, alternating between growing and shrinking the set
    for (int p = 0; p < PHASES; p++) begin
      steady <= (p == 2);
      if (p == 4) stall_go <= 1'b1;
      ins_share = (p % 2 == 0) ? 110 : 40;
      rem_share = (p % 2 == 0) ? 30 : 90;
      for (int n = 0; n < PHASE_LEN; n++) begin
        r = $urandom_range(199);
        if (r == 0)                                c = CMD_CLEAR;
        else if (r <= ins_share)                   c = CMD_INSERT;
        else if (r <= ins_share + rem_share)       c = CMD_REMOVE;
        else if (r <= ins_share + rem_share + 24)  c = CMD_CONTAINS;
        else if (r <= ins_share + rem_share + 50)  c = CMD_READ;
        else                                       c = CMD_W'($urandom_range(5, 7));
        if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
        else                         k = $urandom;
        if (model_size > 0 && $urandom_range(3) != 0)
          rk = RANK_W'($urandom_range(model_size - 1));
        else
          rk = RANK_W'($urandom);
        offer_cmd(c, k, rk, 1'b0, '0);
      end
      // every phase ends with the command side paused until all results are in
      wait_drained();
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (CAPACITY + 10) @(posedge clk);

    $display("covered %0d commands: peak set size %0d of %0d, %0d inserts refused as full,",
             n_sent, peak_size, CAPACITY, n_refused);
    $display("%0d clears, extreme keys and ranks, unused codes, one long result hold-off",
             n_clears);
    if (mismatches == 0) begin
      $display("sorted_key_set_top regression: pass");
    end else begin
      $display("sorted_key_set_top regression: fail");
    end
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin
    #20ms;
    $display("timeout waiting for the block");
    $display("sorted_key_set_top regression: fail");
    $finish;
  end

endmodule

### files.f
design/sks_pkg.sv
design/sks_ctrl.sv
design/sks_dp.sv
design/sorted_key_set_top.sv
design/sks_checker.sv
verif/sorted_key_set_top_test.sv
